// ===== rtl/bdqs_pkg.sv =====
// ----------------------------------------------------------------------------
// bdqs_pkg: shared types for the bounded deque with search
// Operation codes, cell control group and the neighbor chain record.
// ----------------------------------------------------------------------------
package bdqs_pkg;

  localparam int DefaultDepth = 16;
  localparam int ValueWidth   = 32;
  localparam int OpWidth      = 3;

  // Operation codes carried by each input transfer
  typedef enum logic [OpWidth-1:0] {
    OP_ADD_BACK  = 3'd0,
    OP_ADD_FRONT = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_POP_FRONT = 3'd3,
    OP_POP_BACK  = 3'd4,
    OP_CONTAINS  = 3'd5,
    OP_CLEAR     = 3'd6
  } op_e;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic                         cmp_en;     // capture match flag
    logic                         exec_en;    // apply the update
    logic                         shift_in;   // take left neighbor (front insert)
    logic                         append;     // load op value at the count slot
    logic                         take_right; // close a gap (remove / pop front)
    logic signed [ValueWidth-1:0] cmp_value;
    logic signed [ValueWidth-1:0] op_value;
  } cell_ctrl_t;

  // Record passed from each cell to the next one down the row
  typedef struct packed {
    logic                         hit;      // a match lies at or before here
    logic                         last_hit; // first match is the back entry
    logic signed [ValueWidth-1:0] last_val; // value of the back entry
    logic signed [ValueWidth-1:0] pen_val;  // value of the entry before the back
  } chain_t;

endpackage

// ===== rtl/bdqs_cell.sv =====
// ----------------------------------------------------------------------------
// bdqs_cell: one slot of the deque row
// Holds one value, compares it with the search value, and shifts with its
// neighbors to open or close a gap.
// ----------------------------------------------------------------------------
module bdqs_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                                 clk_i,
  input  bdqs_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [CW-1:0]                        count_i,
  input  logic signed [bdqs_pkg::ValueWidth-1:0] left_val_i,
  input  logic signed [bdqs_pkg::ValueWidth-1:0] right_val_i,
  input  bdqs_pkg::chain_t                     chain_i,
  output bdqs_pkg::chain_t                     chain_o,
  output logic signed [bdqs_pkg::ValueWidth-1:0] value_o
);
  import bdqs_pkg::*;

  logic signed [ValueWidth-1:0] value_q, value_d;
  logic                         match_q, match_d;
  logic                         occ, is_last, is_pen, at_count, first_here;

  // Position of this slot relative to the fill count
  assign occ      = {1'b0, count_i} >  (CW+1)'(IDX);
  assign at_count = {1'b0, count_i} == (CW+1)'(IDX);
  assign is_last  = {1'b0, count_i} == (CW+1)'(IDX + 1);
  assign is_pen   = {1'b0, count_i} == (CW+1)'(IDX + 2);

  assign first_here = match_q & ~chain_i.hit;

  // Pass the priority chain and tail taps down the row
  always_comb begin
    chain_o.hit      = chain_i.hit | match_q;
    chain_o.last_hit = chain_i.last_hit | (is_last & first_here);
    chain_o.last_val = chain_i.last_val | (is_last ? value_q : '0);
    chain_o.pen_val  = chain_i.pen_val  | (is_pen  ? value_q : '0);
  end

  // Capture match flag and select the next slot value
  always_comb begin
    match_d = match_q;
    value_d = value_q;
    if (ctrl_i.cmp_en) begin
      match_d = occ && (value_q == ctrl_i.cmp_value);
    end
    if (ctrl_i.exec_en) begin
      if (ctrl_i.shift_in) begin
        value_d = left_val_i;
      end else if (ctrl_i.append && at_count) begin
        value_d = ctrl_i.op_value;
      end else if (ctrl_i.take_right && (chain_i.hit || match_q)) begin
        value_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

  assign value_o = value_q;

endmodule

// ===== rtl/bounded_deque_with_search_top.sv =====
// A result moves from the input transfer through the execute state into the
// output register, waiting in the execute state while a held result stalls.
// Each item is a compare pass over the cell row at the input transfer, then
// one priority-chain and shift pass through the row; no new input is taken
// in the execute state. A result waiting in the output register does not block
// the next input; that item holds in the execute state until the register frees.
// Reset clears the internal count and handshake state, not slots or output data.
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top: bounded deque with delete by value
// Row of value cells with a first-match chain; a two-state sequencer and a
// one-entry output register.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top #(
  parameter int DEPTH = bdqs_pkg::DefaultDepth,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [bdqs_pkg::OpWidth-1:0]           operation_i,
  input  logic signed [bdqs_pkg::ValueWidth-1:0] value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [bdqs_pkg::ValueWidth-1:0] result_value_o,
  output logic                                   found_o,
  output logic                                   overflow_o,
  output logic [CW-1:0]                          entry_count_o,
  output logic                                   is_empty_o,
  output logic signed [bdqs_pkg::ValueWidth-1:0] first_value_o,
  output logic signed [bdqs_pkg::ValueWidth-1:0] last_value_o
);
  import bdqs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                       state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  logic [OpWidth-1:0]           op_q;
  logic signed [ValueWidth-1:0] val_q;

  logic signed [ValueWidth-1:0] res_q, first_q, last_q;
  logic                         found_q, ovf_q;
  logic signed [ValueWidth-1:0] res_d, first_d, last_d;
  logic                         found_d, ovf_d;

  cell_ctrl_t                   ctrl;
  chain_t                       chain [DEPTH+1];
  logic signed [ValueWidth-1:0] cell_val [DEPTH];

  logic in_xfer, out_free, exec_go, full, empty;
  logic signed [ValueWidth-1:0] head0, head1, tail1, tail2;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec_go    = (state_q == ST_EXEC) && out_free;
  assign full       = ({1'b0, count_q} == (CW+1)'(DEPTH));
  assign empty      = (count_q == '0);

  // Broadcast cell control
  always_comb begin
    ctrl            = '0;
    ctrl.cmp_en     = in_xfer;
    ctrl.cmp_value  = value_i;
    ctrl.op_value   = val_q;
    ctrl.exec_en    = exec_go;
    ctrl.shift_in   = (op_q == OP_ADD_FRONT) && !full;
    ctrl.append     = (op_q == OP_ADD_BACK) && !full;
    ctrl.take_right = (op_q == OP_REMOVE) || ((op_q == OP_POP_FRONT) && !empty);
  end

  // Chain head: a pop from the front shifts the whole row
  always_comb begin
    chain[0]     = '0;
    chain[0].hit = (op_q == OP_POP_FRONT);
  end

  // Cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ValueWidth-1:0] left_val, right_val;
    if (g == 0) begin : g_left_head
      assign left_val = val_q;
    end else begin : g_left_cell
      assign left_val = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_right_end
      assign right_val = cell_val[g];
    end else begin : g_right_cell
      assign right_val = cell_val[g+1];
    end
    bdqs_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .chain_i     (chain[g]),
      .chain_o     (chain[g+1]),
      .value_o     (cell_val[g])
    );
  end

  assign head0 = cell_val[0];
  assign head1 = cell_val[1];
  assign tail1 = chain[DEPTH].last_val;
  assign tail2 = chain[DEPTH].pen_val;

  // Work out the result and the new count from the state before the update
  always_comb begin
    count_d = count_q;
    res_d   = '0;
    found_d = 1'b0;
    ovf_d   = 1'b0;
    first_d = head0;
    last_d  = tail1;
    case (op_e'(op_q))
      OP_ADD_BACK: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
          first_d = empty ? val_q : head0;
          last_d  = val_q;
        end
      end
      OP_ADD_FRONT: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
          first_d = val_q;
          last_d  = empty ? val_q : tail1;
        end
      end
      OP_REMOVE: begin
        if (chain[DEPTH].hit) begin
          res_d   = val_q;
          found_d = 1'b1;
          count_d = count_q - CW'(1);
          first_d = chain[1].hit ? head1 : head0;
          last_d  = chain[DEPTH].last_hit ? tail2 : tail1;
        end
      end
      OP_POP_FRONT: begin
        if (!empty) begin
          res_d   = head0;
          found_d = 1'b1;
          count_d = count_q - CW'(1);
          first_d = head1;
        end
      end
      OP_POP_BACK: begin
        if (!empty) begin
          res_d   = tail1;
          found_d = 1'b1;
          count_d = count_q - CW'(1);
          last_d  = tail2;
        end
      end
      OP_CONTAINS: begin
        found_d = chain[DEPTH].hit;
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (count_d == '0) begin
      first_d = '0;
      last_d  = '0;
    end
  end

  // Sequencer and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the operation and the result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= operation_i;
      val_q <= value_i;
    end
    if (exec_go) begin
      res_q   <= res_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign found_o        = found_q;
  assign overflow_o     = ovf_q;
  assign first_value_o  = first_q;
  assign last_value_o   = last_q;

  // Count and empty flag follow the committed count
  logic [CW-1:0] cnt_out_q;
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      cnt_out_q <= count_d;
    end
  end
  assign entry_count_o = cnt_out_q;
  assign is_empty_o    = (cnt_out_q == '0);

endmodule
